/* design/swfbc_pkg.sv */
// Shared types and constants for the size-window free-block cache.
// Used by the cache top level and by its port checker; depends on nothing.
package swfbc_pkg;

  // Cache geometry and address width.
  localparam int CACHE_DEPTH = 24;
  localparam int ADDR_BITS   = 48;

  // Slot index and fill count widths.
  localparam int IDX_W = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;
  localparam int CNT_W = $clog2(CACHE_DEPTH + 1);

  // Stream payload widths, padded to whole bytes.
  localparam int IN_DATA_W  = ((2 * ADDR_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((2 * ADDR_BITS + 7) / 8) * 8;

  // Operation codes carried in the input tuser bit.
  localparam logic OP_TAKE = 1'b0;
  localparam logic OP_PUT  = 1'b1;

  // One cached free block.
  typedef struct packed {
    logic [ADDR_BITS-1:0] base;
    logic [ADDR_BITS-1:0] len;
  } entry_t;

endpackage

/* design/size_window_free_block_cache.sv */
// Size-window free-block cache: slot memory, scan sequencer and result register.
// Depends on swfbc_pkg for geometry, entry type and operation codes.
//
//   Channel   Dir  tuser            tdata
//   in_*      in   [0] operation    [47:0] request_len, [95:48] block_base
//   out_*     out  [0] success      [47:0] found_base,  [95:48] granted_len
//
// A put's result is valid in the cycle after acceptance.
// A take reads one slot per cycle through the registered memory port and
// checks it in the following cycle: a miss ends once all count slots are checked,
// while a hit in slot i then reads the last slot and moves it into slot i.
// Only one transaction is in flight; in_tready is low until the result is taken.
// Reset (rst_n low, synchronous) empties the cache; slot contents need no clearing.
module size_window_free_block_cache (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [swfbc_pkg::IN_DATA_W-1:0] in_tdata,   // request_len, block_base
  input  logic [0:0]                      in_tuser,   // operation
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [swfbc_pkg::OUT_DATA_W-1:0] out_tdata, // found_base, granted_len
  output logic [0:0]                      out_tuser   // success
);

  localparam int AB = swfbc_pkg::ADDR_BITS;
  localparam int IW = swfbc_pkg::IDX_W;
  localparam int CW = swfbc_pkg::CNT_W;

  // Sequencer states.
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_LAST = 2'd2;
  localparam logic [1:0] ST_MOVE = 2'd3;

  localparam logic [CW-1:0] DEPTH_CNT = CW'(swfbc_pkg::CACHE_DEPTH);

  logic [1:0]          state_r;
  logic [CW-1:0]       count_r;
  logic [CW-1:0]       rd_idx_r;
  logic                cmp_vld_r;
  logic [IW-1:0]       cmp_idx_r;
  logic [IW-1:0]       hit_idx_r;
  logic [AB-1:0]       need_r;
  logic [AB-1:0]       top_r;
  logic                out_vld_r;
  logic                out_ok_r;
  logic [AB-1:0]       out_base_r;
  logic [AB-1:0]       out_len_r;

  swfbc_pkg::entry_t   mem [swfbc_pkg::CACHE_DEPTH];
  swfbc_pkg::entry_t   rd_data_r;

  logic                in_acc;
  logic                in_op;
  logic [AB-1:0]       in_len;
  logic [AB-1:0]       in_base;
  logic                hit;
  logic                more;
  logic                rd_en;
  logic [IW-1:0]       rd_addr;
  logic                wr_en;
  logic [IW-1:0]       wr_addr;
  swfbc_pkg::entry_t   wr_data;
  logic [CW-1:0]       last_cnt;

  // Unpack the input transaction.
  assign in_op     = in_tuser[0];
  assign in_len    = in_tdata[AB-1:0];
  assign in_base   = in_tdata[2*AB-1:AB];
  assign in_tready = (state_r == ST_IDLE) && !out_vld_r;
  assign in_acc    = in_tvalid && in_tready;

  // Shared window compare on the slot just read.
  assign hit  = cmp_vld_r && (rd_data_r.len >= need_r) && (rd_data_r.len <= top_r);
  assign more = rd_idx_r < count_r;
  assign last_cnt = count_r - CW'(1);

  // Memory port control.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = rd_idx_r[IW-1:0];
    wr_en   = 1'b0;
    wr_addr = count_r[IW-1:0];
    wr_data = '{base: in_base, len: in_len};
    unique case (state_r)
      ST_IDLE: begin
        wr_en = in_acc && (in_op == swfbc_pkg::OP_PUT) && (count_r < DEPTH_CNT);
      end
      ST_SCAN: begin
        rd_en = !hit && more;
      end
      ST_LAST: begin
        rd_en   = 1'b1;
        rd_addr = last_cnt[IW-1:0];
      end
      ST_MOVE: begin
        wr_en   = 1'b1;
        wr_addr = hit_idx_r;
        wr_data = rd_data_r;
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  // Slot memory with a registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Control sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      count_r   <= '0;
      rd_idx_r  <= '0;
      cmp_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (out_vld_r && out_tready) begin
        out_vld_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            if (in_op == swfbc_pkg::OP_PUT) begin
              out_vld_r <= 1'b1;
              if (count_r < DEPTH_CNT) begin
                count_r <= count_r + CW'(1);
              end
            end else begin
              rd_idx_r  <= '0;
              cmp_vld_r <= 1'b0;
              state_r   <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (hit) begin
            cmp_vld_r <= 1'b0;
            state_r   <= ST_LAST;
          end else if (more) begin
            cmp_vld_r <= 1'b1;
            rd_idx_r  <= rd_idx_r + CW'(1);
          end else begin
            cmp_vld_r <= 1'b0;
            out_vld_r <= 1'b1;
            state_r   <= ST_IDLE;
          end
        end
        ST_LAST: begin
          state_r <= ST_MOVE;
        end
        ST_MOVE: begin
          count_r   <= last_cnt;
          out_vld_r <= 1'b1;
          state_r   <= ST_IDLE;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // Payload registers: request window, scan position and result fields.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      need_r     <= in_len;
      top_r      <= in_len[AB-1] ? {AB{1'b1}} : {in_len[AB-2:0], 1'b0};
      out_base_r <= '0;
      if (in_op == swfbc_pkg::OP_PUT) begin
        out_ok_r  <= (count_r < DEPTH_CNT);
        out_len_r <= '0;
      end else begin
        out_ok_r  <= 1'b0;
        out_len_r <= in_len;
      end
    end
    if (state_r == ST_SCAN) begin
      if (hit) begin
        hit_idx_r  <= cmp_idx_r;
        out_ok_r   <= 1'b1;
        out_base_r <= rd_data_r.base;
        out_len_r  <= rd_data_r.len;
      end else if (more) begin
        cmp_idx_r <= rd_idx_r[IW-1:0];
      end
    end
  end

  // Output channel.
  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_ok_r;
  assign out_tdata  = {{(swfbc_pkg::OUT_DATA_W - 2 * AB){1'b0}}, out_len_r, out_base_r};

endmodule

/* design/swfbc_checker.sv */
// Port-level checker for the size-window free-block cache, bound to the top level.
// Depends on swfbc_pkg for the field widths.
module swfbc_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic [swfbc_pkg::IN_DATA_W-1:0]  in_tdata,
  input logic [0:0]                       in_tuser,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [swfbc_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic [0:0]                       out_tuser
);

  localparam int AB = swfbc_pkg::ADDR_BITS;

  // A pending result is held until the transaction completes.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // Only one transaction is in flight at a time.
  a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted again while busy");

  // No input is taken while a result still waits.
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !out_tvalid)
    else $error("input ready while result pending");

  // A failed request never reports a base address.
  a_miss_base: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata[AB-1:0] == '0)
    else $error("nonzero base on failed request");

endmodule

bind size_window_free_block_cache swfbc_checker u_swfbc_checker (.*);

/* tb/size_window_free_block_cache_tb.sv */
// Testbench for the size-window free-block cache: random and directed put/take traffic
// checked against a behavioral cache model on every result. Depends on swfbc_pkg and
// on the size_window_free_block_cache top level.
`timescale 1ns / 100ps

module size_window_free_block_cache_tb;

  localparam int ADDR_BITS   = swfbc_pkg::ADDR_BITS;
  localparam int CACHE_DEPTH = swfbc_pkg::CACHE_DEPTH;
  localparam int IN_DATA_W   = swfbc_pkg::IN_DATA_W;
  localparam int OUT_DATA_W  = swfbc_pkg::OUT_DATA_W;

  localparam logic [ADDR_BITS-1:0] LEN_MAX  = '1;
  localparam logic [ADDR_BITS-1:0] LEN_HALF = LEN_MAX >> 1;
  localparam int                   PHASE_ITEMS = 410;

  // One request as it goes into the input stream.
  typedef struct {
    logic                 op;
    logic [ADDR_BITS-1:0] len;
    logic [ADDR_BITS-1:0] base;
  } block_req_t;

  // One result as it comes out of the result stream.
  typedef struct {
    logic                 success;
    logic [ADDR_BITS-1:0] found_base;
    logic [ADDR_BITS-1:0] granted_len;
  } grant_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [0:0]            in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [0:0]            out_tuser;

  // Requests waiting to be driven, and results the model says are still due.
  block_req_t            req_queue[$];
  grant_t                pending_grants[$];

  // Model copy of the cache contents.
  logic [ADDR_BITS-1:0]  slot_base[CACHE_DEPTH];
  logic [ADDR_BITS-1:0]  slot_len[CACHE_DEPTH];
  int                    slot_fill = 0;

  // Lengths recently released, used to aim takes at the window.
  logic [ADDR_BITS-1:0]  recent_len[$];

  int                    sender_idle_pct = 0;
  int                    receiver_stall_pct = 0;
  int                    error_count = 0;
  int                    queued_count = 0;

  block_req_t            drive_req;
  block_req_t            seen_req;
  grant_t                want_grant;
  grant_t                got_grant;

  size_window_free_block_cache dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // request_len, block_base
    .in_tuser   (in_tuser),   // operation
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // found_base, granted_len
    .out_tuser  (out_tuser)   // success
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Every mismatch ends up here: one line, one count.
  task automatic report_error(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    error_count++;
  endtask

  // Applies one request to the model cache and returns the result it must produce.
  task automatic apply_cache_op(input block_req_t req, output grant_t g);
    logic [ADDR_BITS-1:0] top;
    int                   last;
    g.success     = 1'b0;
    g.found_base  = '0;
    g.granted_len = '0;
    if (req.op == swfbc_pkg::OP_TAKE) begin
      // Window upper edge is twice the request, clamped instead of wrapping.
      top = (req.len > LEN_HALF) ? LEN_MAX : (req.len << 1);
      g.granted_len = req.len;
      for (int i = 0; i < slot_fill; i++) begin
        if (slot_len[i] >= req.len && slot_len[i] <= top) begin
          last          = slot_fill - 1;
          g.success     = 1'b1;
          g.found_base  = slot_base[i];
          g.granted_len = slot_len[i];
          slot_base[i]  = slot_base[last];
          slot_len[i]   = slot_len[last];
          slot_fill     = last;
          break;
        end
      end
    end else if (slot_fill < CACHE_DEPTH) begin
      slot_base[slot_fill] = req.base;
      slot_len[slot_fill]  = req.len;
      slot_fill++;
      g.success = 1'b1;
    end
  endtask

  function automatic logic [ADDR_BITS-1:0] rand_addr();
    return ADDR_BITS'({$urandom, $urandom});
  endfunction

  // Lengths lean toward small values so takes hit often, with extremes mixed in.
  function automatic logic [ADDR_BITS-1:0] rand_len();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return ADDR_BITS'($urandom_range(0, 40));
      5:             return '0;
      6:             return LEN_MAX - ADDR_BITS'($urandom_range(0, 2));
      7:             return rand_addr();
      8:             return LEN_HALF + ADDR_BITS'($urandom_range(0, 2)) - 1'b1;
      default:       return ADDR_BITS'(1) << $urandom_range(0, ADDR_BITS - 1);
    endcase
  endfunction

  // Uniform value in [lo, hi]; the span always fits in 64 bits.
  function automatic logic [ADDR_BITS-1:0] rand_between(input logic [ADDR_BITS-1:0] lo,
                                                        input logic [ADDR_BITS-1:0] hi);
    logic [63:0] span;
    span = 64'(hi) - 64'(lo) + 64'd1;
    return lo + ADDR_BITS'({$urandom, $urandom} % span);
  endfunction

  task automatic push_put(input logic [ADDR_BITS-1:0] len, input logic [ADDR_BITS-1:0] base);
    block_req_t r;
    r.op   = swfbc_pkg::OP_PUT;
    r.len  = len;
    r.base = base;
    req_queue.push_back(r);
    recent_len.push_back(len);
    if (recent_len.size() > 32) void'(recent_len.pop_front());
    queued_count++;
  endtask

  task automatic push_take(input logic [ADDR_BITS-1:0] len);
    block_req_t r;
    r.op   = swfbc_pkg::OP_TAKE;
    r.len  = len;
    r.base = rand_addr();
    req_queue.push_back(r);
    queued_count++;
  endtask

  // Take length aimed at a released length: mostly inside its window, sometimes just out.
  function automatic logic [ADDR_BITS-1:0] aimed_len();
    logic [ADDR_BITS-1:0] s;
    logic [ADDR_BITS-1:0] lo;
    if (recent_len.size() == 0) return rand_len();
    s  = recent_len[$urandom_range(0, recent_len.size() - 1)];
    lo = (s >> 1) + ADDR_BITS'(s[0]);
    case ($urandom_range(0, 9))
      0:       return (s == LEN_MAX) ? s : s + 1'b1;
      1:       return (lo == 0) ? lo : lo - 1'b1;
      2:       return lo;
      3:       return s;
      default: return rand_between(lo, s);
    endcase
  endfunction

  // One stretch of traffic: fill bursts, drains, mixed runs or raw noise.
  task automatic add_segment();
    int n;
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4: begin
        // Enough puts to reach a full cache from any state, then overflow it.
        n = $urandom_range(25, 30);
        repeat (n) push_put(rand_len(), rand_addr());
      end
      5, 6, 7, 8, 9, 10: begin
        n = $urandom_range(10, 30);
        repeat (n) push_take(aimed_len());
      end
      11, 12, 13, 14, 15, 16: begin
        n = $urandom_range(10, 25);
        repeat (n) begin
          if ($urandom_range(0, 1) == 0) push_put(rand_len(), rand_addr());
          else push_take(aimed_len());
        end
      end
      default: begin
        n = $urandom_range(5, 10);
        repeat (n) begin
          if ($urandom_range(0, 1) == 0) push_put(rand_len(), rand_addr());
          else push_take(rand_len());
        end
      end
    endcase
  endtask

  // Hold until every queued request has been driven and answered.
  task automatic wait_drained();
    while (req_queue.size() != 0 || in_tvalid || pending_grants.size() != 0) @(negedge clk);
  endtask

  // Input driver: the next request goes out once the current one is accepted.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (req_queue.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
        drive_req = req_queue.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= {drive_req.base, drive_req.len};
        in_tuser  <= drive_req.op;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Result-side back-pressure.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
  end

  // Monitor: check each result transaction first, then log any accepted request.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got_grant.success     = out_tuser[0];
        got_grant.found_base  = out_tdata[ADDR_BITS-1:0];
        got_grant.granted_len = out_tdata[2*ADDR_BITS-1:ADDR_BITS];
        if (pending_grants.size() == 0) begin
          report_error("result transaction with no request outstanding");
        end else begin
          want_grant = pending_grants.pop_front();
          if (got_grant.success !== want_grant.success)
            report_error($sformatf("success got %b want %b",
                                   got_grant.success, want_grant.success));
          if (got_grant.found_base !== want_grant.found_base)
            report_error($sformatf("found_base got %h want %h",
                                   got_grant.found_base, want_grant.found_base));
          if (got_grant.granted_len !== want_grant.granted_len)
            report_error($sformatf("granted_len got %h want %h",
                                   got_grant.granted_len, want_grant.granted_len));
        end
      end
      if (in_tvalid && in_tready) begin
        seen_req.op   = in_tuser[0];
        seen_req.len  = in_tdata[ADDR_BITS-1:0];
        seen_req.base = in_tdata[2*ADDR_BITS-1:ADDR_BITS];
        apply_cache_op(seen_req, want_grant);
        pending_grants.push_back(want_grant);
      end
    end
  end

  // Stimulus and phase control.
  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty cache, zero and extreme lengths, saturated window, window edges.
    push_take('0);
    push_take(LEN_MAX);
    push_put('0, LEN_MAX);
    push_put(LEN_MAX, '0);
    push_put(LEN_HALF, {(ADDR_BITS/2){2'b01}});
    push_put(LEN_HALF + 1'b1, {(ADDR_BITS/2){2'b10}});
    push_take('0);
    push_take(LEN_HALF + 1'b1);
    push_take(LEN_HALF >> 1);
    push_take(LEN_MAX);
    push_take(ADDR_BITS'(5));
    push_put(ADDR_BITS'(10), ADDR_BITS'(1));
    push_take(ADDR_BITS'(4));
    push_take(ADDR_BITS'(11));
    push_take(ADDR_BITS'(5));
    push_put(ADDR_BITS'(7), ADDR_BITS'(2));
    push_put(ADDR_BITS'(3), ADDR_BITS'(3));
    push_take(ADDR_BITS'(3));
    push_take(ADDR_BITS'(7));
    wait_drained();

    // Random traffic under four idling phases.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1:       begin sender_idle_pct = 86; receiver_stall_pct = 0;  end
        2:       begin sender_idle_pct = 0;  receiver_stall_pct = 86; end
        default: begin sender_idle_pct = 18; receiver_stall_pct = 18; end
      endcase
      queued_count = 0;
      while (queued_count < PHASE_ITEMS) add_segment();
      wait_drained();
    end

    // Let any stray result show up before the verdict.
    repeat (40) @(negedge clk);
    if (pending_grants.size() != 0)
      report_error($sformatf("%0d results never arrived", pending_grants.size()));
    if (error_count == 0) begin
      $display("** size_window_free_block_cache: PASSED **");
    end else begin
      $display("** size_window_free_block_cache: FAILED **");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #8_000_000;
    $display("** size_window_free_block_cache: FAILED **");
    $finish;
  end

endmodule

/* size_window_free_block_cache.f */
design/swfbc_pkg.sv
design/size_window_free_block_cache.sv
design/swfbc_checker.sv
tb/size_window_free_block_cache_tb.sv
